[hw/rtl/bellman_ford_shortest_paths_unit_defines.svh]
// assertion macros for the checker module
`ifndef BELLMAN_FORD_SHORTEST_PATHS_UNIT_DEFINES_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bfsp_pkg.sv]
package bfsp_pkg;

	// default sizes
	localparam int MAX_NODES_DEF = 64;
	localparam int MAX_EDGES_DEF = 1024;

	// fixed field widths
	localparam int NODE_W   = 6;
	localparam int CNT_W    = 7;
	localparam int WEIGHT_W = 32;
	localparam int DIST_W   = 48;

	localparam logic signed [DIST_W-1:0] INT_MAX_DIST = 48'sd2147483647;

	// configuration register indexes
	localparam logic CFG_NODE_COUNT  = 1'b0;
	localparam logic CFG_SOURCE_NODE = 1'b1;

	// one stored edge
	typedef struct packed {
		logic [NODE_W-1:0]          from_node;
		logic [NODE_W-1:0]          to_node;
		logic signed [WEIGHT_W-1:0] weight;
	} edge_ent_t;

	// one distance entry
	typedef struct packed {
		logic                     ok;
		logic signed [DIST_W-1:0] val;
	} dist_ent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_EDGE_RD,
		ST_DIST_RD,
		ST_RELAX,
		ST_PASS_END,
		ST_NEG,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              clear_edges;
		logic              ptr_clr;
		logic              edge_rd;
		logic              dist_rd;
		logic              relax;
		logic              init_wr;
		logic              out_rd;
		logic              out_last;
		logic              neg_emit;
		logic [NODE_W-1:0] node;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CNT_W-1:0] n_eff;
		logic             edges_done;
		logic             upd;
	} stat_t;

endpackage

[hw/rtl/bfsp_ctrl.sv]
module bfsp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            req_type,
	input  bfsp_pkg::stat_t stat,
	output bfsp_pkg::cmd_t  cmd,
	output logic            busy
);

	bfsp_pkg::state_t state_q, state_d;
	logic [bfsp_pkg::CNT_W-1:0] i_q;
	logic [bfsp_pkg::CNT_W-1:0] pass_q;
	logic                       changed_q;
	logic [bfsp_pkg::CNT_W-1:0] n_last;
	logic                       i_at_last;
	logic                       pass_at_last;

	assign n_last       = stat.n_eff - bfsp_pkg::CNT_W'(1);
	assign i_at_last    = (i_q == n_last);
	assign pass_at_last = (pass_q == n_last);
	assign busy         = (state_q != bfsp_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bfsp_pkg::ST_IDLE: begin
				if (start && req_type) state_d = bfsp_pkg::ST_INIT;
			end
			bfsp_pkg::ST_INIT: begin
				if (i_at_last) state_d = bfsp_pkg::ST_EDGE_RD;
			end
			bfsp_pkg::ST_EDGE_RD: begin
				state_d = stat.edges_done ? bfsp_pkg::ST_PASS_END : bfsp_pkg::ST_DIST_RD;
			end
			bfsp_pkg::ST_DIST_RD: state_d = bfsp_pkg::ST_RELAX;
			bfsp_pkg::ST_RELAX:   state_d = bfsp_pkg::ST_EDGE_RD;
			bfsp_pkg::ST_PASS_END: begin
				if (!changed_q) state_d = bfsp_pkg::ST_OUT;
				else if (pass_at_last) state_d = bfsp_pkg::ST_NEG;
				else state_d = bfsp_pkg::ST_EDGE_RD;
			end
			bfsp_pkg::ST_NEG: state_d = bfsp_pkg::ST_IDLE;
			bfsp_pkg::ST_OUT: begin
				if (i_at_last) state_d = bfsp_pkg::ST_IDLE;
			end
			default: state_d = bfsp_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			bfsp_pkg::ST_IDLE: begin
				cmd.load = start && !req_type;
			end
			bfsp_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				cmd.ptr_clr = 1'b1;
				cmd.node    = i_q[bfsp_pkg::NODE_W-1:0];
			end
			bfsp_pkg::ST_EDGE_RD: begin
				cmd.edge_rd = !stat.edges_done;
			end
			bfsp_pkg::ST_DIST_RD: cmd.dist_rd = 1'b1;
			bfsp_pkg::ST_RELAX:   cmd.relax = 1'b1;
			bfsp_pkg::ST_PASS_END: begin
				cmd.ptr_clr     = 1'b1;
				cmd.clear_edges = !changed_q || pass_at_last;
			end
			bfsp_pkg::ST_NEG: cmd.neg_emit = 1'b1;
			bfsp_pkg::ST_OUT: begin
				cmd.out_rd   = 1'b1;
				cmd.out_last = i_at_last;
				cmd.node     = i_q[bfsp_pkg::NODE_W-1:0];
			end
			default: cmd = '0;
		endcase
	end

	// state, node counter, pass counter, change flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bfsp_pkg::ST_IDLE;
			i_q       <= '0;
			pass_q    <= '0;
			changed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				bfsp_pkg::ST_IDLE: begin
					i_q       <= '0;
					pass_q    <= '0;
					changed_q <= 1'b0;
				end
				bfsp_pkg::ST_INIT: begin
					i_q <= i_at_last ? '0 : i_q + bfsp_pkg::CNT_W'(1);
				end
				bfsp_pkg::ST_RELAX: begin
					if (stat.upd) changed_q <= 1'b1;
				end
				bfsp_pkg::ST_PASS_END: begin
					i_q <= '0;
					if (changed_q && !pass_at_last) begin
						pass_q    <= pass_q + bfsp_pkg::CNT_W'(1);
						changed_q <= 1'b0;
					end
				end
				bfsp_pkg::ST_OUT: i_q <= i_q + bfsp_pkg::CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/bfsp_dp.sv]
module bfsp_dp #(
	parameter int MAX_NODES = bfsp_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bfsp_pkg::cmd_t                      cmd,
	output bfsp_pkg::stat_t                     stat,
	input  logic                                cfg_wr,
	input  logic                                cfg_index,
	input  logic [bfsp_pkg::CNT_W-1:0]          cfg_data,
	input  logic [bfsp_pkg::NODE_W-1:0]         edge_from,
	input  logic [bfsp_pkg::NODE_W-1:0]         edge_to,
	input  logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weight,
	output logic                                strobe,
	output logic [bfsp_pkg::NODE_W-1:0]         node_index,
	output logic signed [bfsp_pkg::DIST_W-1:0]  distance,
	output logic                                reached,
	output logic                                negative_cycle,
	output logic                                last
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);

	// storage
	bfsp_pkg::edge_ent_t edge_mem [MAX_EDGES];
	bfsp_pkg::dist_ent_t dist_mem [MAX_NODES];

	logic [bfsp_pkg::CNT_W-1:0]  node_count_q;
	logic [bfsp_pkg::NODE_W-1:0] source_q;
	logic [ECW-1:0]              edge_total_q;
	logic [ECW-1:0]              rd_ptr_q;
	logic                        full;

	bfsp_pkg::edge_ent_t edge_q;
	bfsp_pkg::dist_ent_t rda_q;
	bfsp_pkg::dist_ent_t rdb_q;

	logic [bfsp_pkg::CNT_W-1:0]  n_eff;
	logic [bfsp_pkg::NODE_W-1:0] addr_a;
	logic                        u_ok;
	logic                        v_ok;
	logic signed [bfsp_pkg::DIST_W-1:0] cand;
	logic                        upd;
	logic                        dist_we;
	logic [NW-1:0]               dist_wa;
	bfsp_pkg::dist_ent_t         dist_wd;

	logic                        vld_s1;
	logic                        neg_s1;
	logic                        last_s1;
	logic [bfsp_pkg::NODE_W-1:0] idx_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= bfsp_pkg::CNT_W'(1);
			source_q     <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				bfsp_pkg::CFG_NODE_COUNT:  node_count_q <= cfg_data;
				bfsp_pkg::CFG_SOURCE_NODE: source_q <= cfg_data[bfsp_pkg::NODE_W-1:0];
				default: ;
			endcase
		end
	end

	// active node count, clamped to 1..MAX_NODES
	always_comb begin
		if (node_count_q == '0) n_eff = bfsp_pkg::CNT_W'(1);
		else if (node_count_q > bfsp_pkg::CNT_W'(MAX_NODES)) n_eff = bfsp_pkg::CNT_W'(MAX_NODES);
		else n_eff = node_count_q;
	end

	// edge count and read pointer
	assign full = (edge_total_q == ECW'(MAX_EDGES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			rd_ptr_q     <= '0;
		end else begin
			if (cmd.clear_edges) edge_total_q <= '0;
			else if (cmd.load && !full) edge_total_q <= edge_total_q + ECW'(1);
			if (cmd.ptr_clr) rd_ptr_q <= '0;
			else if (cmd.edge_rd) rd_ptr_q <= rd_ptr_q + ECW'(1);
		end
	end

	// edge store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			edge_mem[edge_total_q[EAW-1:0]] <= '{from_node: edge_from, to_node: edge_to,
				weight: edge_weight};
		end
		if (cmd.edge_rd) edge_q <= edge_mem[rd_ptr_q[EAW-1:0]];
	end

	// relaxation of the edge held in edge_q
	assign u_ok = ({1'b0, edge_q.from_node} < n_eff);
	assign v_ok = ({1'b0, edge_q.to_node} < n_eff);
	assign cand = rda_q.val + bfsp_pkg::DIST_W'(edge_q.weight);
	assign upd  = u_ok && v_ok && rda_q.ok && (!rdb_q.ok || (cand < rdb_q.val));

	// distance store write port: init sweep or improved distance
	always_comb begin
		dist_we = 1'b0;
		dist_wa = cmd.node[NW-1:0];
		dist_wd = '{ok: 1'b0, val: bfsp_pkg::INT_MAX_DIST};
		if (cmd.init_wr) begin
			dist_we = 1'b1;
			if (cmd.node == source_q) dist_wd = '{ok: 1'b1, val: '0};
		end else if (cmd.relax && upd) begin
			dist_we = 1'b1;
			dist_wa = edge_q.to_node[NW-1:0];
			dist_wd = '{ok: 1'b1, val: cand};
		end
	end

	assign addr_a = cmd.dist_rd ? edge_q.from_node : cmd.node;

	// distance store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		if (cmd.dist_rd || cmd.out_rd) rda_q <= dist_mem[addr_a[NW-1:0]];
		if (cmd.dist_rd) rdb_q <= dist_mem[edge_q.to_node[NW-1:0]];
	end

	// result pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			strobe <= 1'b0;
		end else begin
			vld_s1 <= cmd.out_rd;
			neg_s1 <= cmd.neg_emit;
			strobe <= vld_s1 || neg_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		idx_s1         <= cmd.node;
		last_s1        <= cmd.out_last;
		node_index     <= neg_s1 ? '0 : idx_s1;
		distance       <= neg_s1 ? '0 : (rda_q.ok ? rda_q.val : bfsp_pkg::INT_MAX_DIST);
		reached        <= !neg_s1 && rda_q.ok;
		negative_cycle <= neg_s1;
		last           <= neg_s1 || last_s1;
	end

	assign stat.n_eff      = n_eff;
	assign stat.edges_done = (rd_ptr_q == edge_total_q);
	assign stat.upd        = upd;

endmodule

[hw/rtl/bellman_ford_shortest_paths_unit.sv]
// single-source shortest paths over a loaded list of directed, signed-weight edges
// input: an item is taken when start is high and busy is low. req_type 0 appends
// the edge {edge_from, edge_to, edge_weight} to the edge store, so loads can
// follow back to back; loads past MAX_EDGES are dropped. req_type 1
// starts a run from source_node over the first node_count nodes and empties the
// edge store when done; busy stays high for the whole run.
// run, with n active nodes: the distance store is first set up, then each pass
// takes every stored edge through an edge store read, a two-port distance read
// and an add/compare/write, then one end-of-list check and one pass-end step;
// up to n passes, and a pass with no change ends the run early.
// results: after the passes end each node's distance is read and registered
// through the result pipeline; strobe marks each result for one cycle, one per
// cycle for nodes 0..n-1, last set on the final one; busy drops before that beat.
// a negative cycle reachable from the source gives one result instead, with
// negative_cycle and last set. the receiver cannot stall; results just go out.
// config: cfg_ready is always high; index 0 is node_count, index 1 source_node;
// write only while no run is in progress.
// reset: empties the edge store, node_count goes to 1, source_node to 0.
module bellman_ford_shortest_paths_unit #(
	parameter int MAX_NODES = bfsp_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 req_type,
	input  logic [bfsp_pkg::NODE_W-1:0]          edge_from,
	input  logic [bfsp_pkg::NODE_W-1:0]          edge_to,
	input  logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [bfsp_pkg::CNT_W-1:0]           cfg_data,
	output logic                                 strobe,
	output logic [bfsp_pkg::NODE_W-1:0]          node_index,
	output logic signed [bfsp_pkg::DIST_W-1:0]   distance,
	output logic                                 reached,
	output logic                                 negative_cycle,
	output logic                                 last
);

	bfsp_pkg::cmd_t  cmd;
	bfsp_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	// sequencer
	bfsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	// stores, relaxation and result registers
	bfsp_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.edge_from      (edge_from),
		.edge_to        (edge_to),
		.edge_weight    (edge_weight),
		.strobe         (strobe),
		.node_index     (node_index),
		.distance       (distance),
		.reached        (reached),
		.negative_cycle (negative_cycle),
		.last           (last)
	);

endmodule

[hw/rtl/bfsp_chk.sv]
`include "bellman_ford_shortest_paths_unit_defines.svh"

module bfsp_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                req_type,
	input logic                                strobe,
	input logic [bfsp_pkg::NODE_W-1:0]         node_index,
	input logic signed [bfsp_pkg::DIST_W-1:0]  distance,
	input logic                                reached,
	input logic                                negative_cycle,
	input logic                                last
);

	// an accepted run holds the input off
	`BFSP_ASSERT_NEXT(a_run_busy, clk, arst_n, start && !busy && req_type, busy, "run not busy")

	// negative cycle beat has fixed contents
	`BFSP_ASSERT_NOW(a_neg_form, clk, arst_n, strobe && negative_cycle, last && !reached && (node_index == '0) && (distance == '0), "bad negative cycle beat")

	// unreached nodes report the sentinel distance
	`BFSP_ASSERT_NOW(a_unreached, clk, arst_n, strobe && !negative_cycle && !reached, distance == bfsp_pkg::INT_MAX_DIST, "unreached distance wrong")

	// node beats come in consecutive cycles with rising index
	`BFSP_ASSERT_NEXT(a_node_seq, clk, arst_n, strobe && !last, strobe && (node_index == bfsp_pkg::NODE_W'($past(node_index) + 1'b1)), "node beats out of order")

endmodule

bind bellman_ford_shortest_paths_unit bfsp_chk u_bfsp_chk (.*);

[sim/bellman_ford_shortest_paths_unit_tb.sv]
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_unit_tb;

	localparam int NODE_LIMIT = bfsp_pkg::MAX_NODES_DEF;
	localparam int EDGE_LIMIT = bfsp_pkg::MAX_EDGES_DEF;
	localparam int RAND_ITEMS = 350;

	// request codes
	localparam bit REQ_LOAD = 1'b0;
	localparam bit REQ_RUN  = 1'b1;

	// one node result as the block should report it
	typedef struct {
		bit [bfsp_pkg::NODE_W-1:0] node;
		longint                    dist_value;
		bit                        reached;
		bit                        neg;
		bit                        last;
	} node_result_t;

	// shortest path predictor plus the queue of pending node results
	class path_scoreboard;
		bit [bfsp_pkg::CNT_W-1:0]  node_count_reg;
		bit [bfsp_pkg::NODE_W-1:0] source_reg;
		bit [bfsp_pkg::NODE_W-1:0] edge_tail[$];
		bit [bfsp_pkg::NODE_W-1:0] edge_head[$];
		longint                    edge_wt[$];
		node_result_t              expected_results[$];
		int                        mismatches;

		function new();
			node_count_reg = bfsp_pkg::CNT_W'(1);
			source_reg = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic idx, bit [bfsp_pkg::CNT_W-1:0] data);
			if (idx == bfsp_pkg::CFG_NODE_COUNT)
				node_count_reg = data;
			else
				source_reg = data[bfsp_pkg::NODE_W-1:0];
		endfunction

		function bit idle();
			return expected_results.size() == 0;
		endfunction

		// an accepted request: store the edge, or relax all edges and queue results
		function void accept_request(bit rt, bit [bfsp_pkg::NODE_W-1:0] from_n,
				bit [bfsp_pkg::NODE_W-1:0] to_n, logic signed [bfsp_pkg::WEIGHT_W-1:0] wt);
			int n;
			int pass;
			int u;
			int v;
			bit changed;
			longint cand;
			longint dist_val[NODE_LIMIT];
			bit dist_ok[NODE_LIMIT];
			node_result_t res;
			if (rt == REQ_LOAD) begin
				if (edge_tail.size() < EDGE_LIMIT) begin
					edge_tail.insert(edge_tail.size(), from_n);
					edge_head.insert(edge_head.size(), to_n);
					edge_wt.insert(edge_wt.size(), longint'(wt));
				end
				return;
			end
			// effective node count
			if (node_count_reg == 0)
				n = 1;
			else if (node_count_reg > NODE_LIMIT)
				n = NODE_LIMIT;
			else
				n = int'(node_count_reg);
			for (int i = 0; i < NODE_LIMIT; i++) begin
				dist_val[i] = longint'(bfsp_pkg::INT_MAX_DIST);
				dist_ok[i] = 1'b0;
			end
			if (source_reg < n) begin
				dist_val[source_reg] = '0;
				dist_ok[source_reg] = 1'b1;
			end
			// relaxation passes in load order, early exit on a quiet pass
			changed = 1'b0;
			for (pass = 0; pass < n; pass++) begin
				changed = 1'b0;
				for (int j = 0; j < edge_tail.size(); j++) begin
					u = int'(edge_tail[j]);
					v = int'(edge_head[j]);
					if (u < n && v < n && dist_ok[u]) begin
						cand = dist_val[u] + edge_wt[j];
						if (!dist_ok[v] || cand < dist_val[v]) begin
							dist_val[v] = cand;
							dist_ok[v] = 1'b1;
							changed = 1'b1;
						end
					end
				end
				if (!changed)
					break;
			end
			edge_tail.delete();
			edge_head.delete();
			edge_wt.delete();
			// still changing in the last pass means a negative cycle
			if (changed) begin
				res.node = '0;
				res.dist_value = '0;
				res.reached = 1'b0;
				res.neg = 1'b1;
				res.last = 1'b1;
				expected_results.insert(expected_results.size(), res);
				return;
			end
			for (int i = 0; i < n; i++) begin
				res.node = i[bfsp_pkg::NODE_W-1:0];
				res.dist_value = dist_ok[i] ? dist_val[i] : longint'(bfsp_pkg::INT_MAX_DIST);
				res.reached = dist_ok[i];
				res.neg = 1'b0;
				res.last = (i == n - 1);
				expected_results.insert(expected_results.size(), res);
			end
		endfunction

		// compare one result beat against the oldest pending result
		function void check_node_result(logic [bfsp_pkg::NODE_W-1:0] idx,
				logic signed [bfsp_pkg::DIST_W-1:0] d, logic r, logic neg, logic lst);
			node_result_t want;
			bit bad;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: node %0d dist %0d reached %0b neg %0b last %0b",
						idx, d, r, neg, lst);
				return;
			end
			want = expected_results.pop_front();
			bad = (idx !== want.node) || (d !== want.dist_value[bfsp_pkg::DIST_W-1:0]) ||
				(r !== want.reached) || (neg !== want.neg) || (lst !== want.last);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch: expected node %0d dist %0d reached %0b neg %0b last %0b",
						want.node, want.dist_value, want.reached, want.neg, want.last);
					$display("                 actual   node %0d dist %0d reached %0b neg %0b last %0b",
						idx, d, r, neg, lst);
				end
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n = 1'b0;
	logic                                 start = 1'b0;
	logic                                 busy;
	logic                                 req_type = 1'b0;
	logic [bfsp_pkg::NODE_W-1:0]          edge_from = '0;
	logic [bfsp_pkg::NODE_W-1:0]          edge_to = '0;
	logic signed [bfsp_pkg::WEIGHT_W-1:0] edge_weight = '0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic                                 cfg_index = bfsp_pkg::CFG_NODE_COUNT;
	logic [bfsp_pkg::CNT_W-1:0]           cfg_data = '0;
	logic                                 strobe;
	logic [bfsp_pkg::NODE_W-1:0]          node_index;
	logic signed [bfsp_pkg::DIST_W-1:0]   distance;
	logic                                 reached;
	logic                                 negative_cycle;
	logic                                 last;

	path_scoreboard sb;

	bellman_ford_shortest_paths_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.edge_weight   (edge_weight),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.strobe        (strobe),
		.node_index    (node_index),
		.distance      (distance),
		.reached       (reached),
		.negative_cycle(negative_cycle),
		.last          (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// result monitor, samples pre-edge values
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_node_result(node_index, distance, reached, negative_cycle, last);
	end

	// present one request and hold it until taken, with an optional idle burst first
	task automatic send_item(input bit rt, input bit [bfsp_pkg::NODE_W-1:0] from_n,
			input bit [bfsp_pkg::NODE_W-1:0] to_n,
			input logic signed [bfsp_pkg::WEIGHT_W-1:0] wt, input bit bursty);
		if (bursty && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rt;
		edge_from <= from_n;
		edge_to <= to_n;
		edge_weight <= wt;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.accept_request(rt, from_n, to_n, wt);
	endtask

	// stop sending and wait until every pending result has come back
	task automatic wait_idle();
		start <= 1'b0;
		while (!sb.idle()) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// one config beat per register, only while idle
	task automatic set_config(input bit [bfsp_pkg::CNT_W-1:0] nc,
			input bit [bfsp_pkg::CNT_W-1:0] src);
		cfg_valid <= 1'b1;
		cfg_index <= bfsp_pkg::CFG_NODE_COUNT;
		cfg_data <= nc;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(bfsp_pkg::CFG_NODE_COUNT, nc);
		cfg_index <= bfsp_pkg::CFG_SOURCE_NODE;
		cfg_data <= src;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(bfsp_pkg::CFG_SOURCE_NODE, src);
		cfg_valid <= 1'b0;
	endtask

	function automatic int eff_nodes(bit [bfsp_pkg::CNT_W-1:0] nc);
		if (nc == 0)
			return 1;
		if (nc > NODE_LIMIT)
			return NODE_LIMIT;
		return int'(nc);
	endfunction

	// mostly small weights so that runs finish with real paths, some extremes
	function automatic logic signed [bfsp_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return $signed($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 60)) - 12;
		endcase
	endfunction

	function automatic bit [bfsp_pkg::NODE_W-1:0] pick_node(int n);
		if ($urandom_range(0, 6) == 0)
			return bfsp_pkg::NODE_W'($urandom_range(0, 63));
		return bfsp_pkg::NODE_W'($urandom_range(0, n - 1));
	endfunction

	initial begin
		bit [bfsp_pkg::CNT_W-1:0] nc;
		bit [bfsp_pkg::CNT_W-1:0] src;
		int n;
		int n_edges;
		int rand_items;
		int grp;
		bit bursty;
		bit calm;

		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// simple chain, maximum weight edge, edge outside active nodes
		set_config(7'd4, 7'd0);
		send_item(REQ_LOAD, 6'd0, 6'd1, 32'sd5, 1'b0);
		send_item(REQ_LOAD, 6'd1, 6'd2, -32'sd3, 1'b0);
		send_item(REQ_LOAD, 6'd3, 6'd2, -32'sd100, 1'b0);
		send_item(REQ_LOAD, 6'd0, 6'd10, 32'sd1, 1'b0);
		send_item(REQ_LOAD, 6'd2, 6'd3, 32'sh7fffffff, 1'b0);
		send_item(REQ_RUN, 6'd63, 6'd63, -32'sd1, 1'b0);
		wait_idle();

		// reachable negative cycle
		set_config(7'd3, 7'd0);
		send_item(REQ_LOAD, 6'd0, 6'd1, 32'sd1, 1'b0);
		send_item(REQ_LOAD, 6'd1, 6'd2, -32'sd2, 1'b0);
		send_item(REQ_LOAD, 6'd2, 6'd1, -32'sd1, 1'b0);
		send_item(REQ_RUN, 6'd0, 6'd0, 32'sd0, 1'b0);
		wait_idle();

		// extreme weights, sum wider than 32 bits
		set_config(7'd3, 7'd0);
		send_item(REQ_LOAD, 6'd0, 6'd1, 32'sh80000000, 1'b0);
		send_item(REQ_LOAD, 6'd0, 6'd2, 32'sh7fffffff, 1'b0);
		send_item(REQ_LOAD, 6'd1, 6'd2, 32'sh80000000, 1'b0);
		send_item(REQ_RUN, 6'd0, 6'd0, 32'sd0, 1'b0);
		wait_idle();

		// source outside active nodes
		set_config(7'd2, 7'd5);
		send_item(REQ_LOAD, 6'd5, 6'd1, 32'sd3, 1'b0);
		send_item(REQ_RUN, 6'd0, 6'd0, 32'sd0, 1'b0);
		wait_idle();

		// node count zero acts as one
		set_config(7'd0, 7'd0);
		send_item(REQ_RUN, 6'd0, 6'd0, 32'sd0, 1'b0);
		wait_idle();

		// node count above the maximum saturates, top node as source
		set_config(7'd127, 7'd63);
		send_item(REQ_LOAD, 6'd63, 6'd0, -32'sd1, 1'b0);
		send_item(REQ_LOAD, 6'd0, 6'd62, 32'sd0, 1'b0);
		send_item(REQ_RUN, 6'd0, 6'd0, 32'sd0, 1'b0);
		wait_idle();

		set_config(7'd64, 7'd0);
		send_item(REQ_LOAD, 6'd0, 6'd63, 32'sh80000000, 1'b0);
		send_item(REQ_RUN, 6'd0, 6'd0, 32'sd0, 1'b0);
		wait_idle();

		// random load groups each closed by a run
		rand_items = 0;
		grp = 0;
		n = 2;
		while (rand_items < RAND_ITEMS) begin
			calm = rand_items >= RAND_ITEMS - 60;
			bursty = !calm && $urandom_range(0, 2) != 0;
			if (!calm && (grp % 3 == 0 || $urandom_range(0, 4) == 0)) begin
				wait_idle();
				case ($urandom_range(0, 19))
					0: nc = '0;
					1: nc = bfsp_pkg::CNT_W'(64);
					2: nc = bfsp_pkg::CNT_W'($urandom_range(65, 127));
					3, 4, 5: nc = bfsp_pkg::CNT_W'($urandom_range(9, 63));
					default: nc = bfsp_pkg::CNT_W'($urandom_range(1, 8));
				endcase
				n = eff_nodes(nc);
				if ($urandom_range(0, 4) == 0)
					src = bfsp_pkg::CNT_W'($urandom_range(0, 127));
				else
					src = bfsp_pkg::CNT_W'($urandom_range(0, n - 1));
				set_config(nc, src);
			end
			n_edges = (n > 8) ? $urandom_range(0, 20) : $urandom_range(0, 24);
			for (int k = 0; k < n_edges; k++) begin
				send_item(REQ_LOAD, pick_node(n), pick_node(n), pick_weight(), bursty);
				rand_items++;
			end
			// sometimes hold the run back until the last run has drained
			if (!calm && $urandom_range(0, 7) == 0)
				wait_idle();
			send_item(REQ_RUN, bfsp_pkg::NODE_W'($urandom), bfsp_pkg::NODE_W'($urandom),
				$signed($urandom), bursty);
			rand_items++;
			grp++;
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.idle())
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
